// ===== hdl/mjpid_pkg.sv =====
// Shared types, constants and fixed-point helpers for the multi-joint PID controller.
package mjpid_pkg;

  localparam int JOINTS    = 32;
  localparam int JW        = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int IDX_W     = 5;
  localparam int DATA_W    = 32;
  localparam int INTEG_W   = 48;
  localparam int TERM_W    = 62;
  localparam int DIFF_W    = 35;
  localparam int PROD_W    = 96;
  localparam int SHR_W     = PROD_W - 16;
  localparam int ISUM_W    = TERM_W + 1;
  localparam int SUM_W     = TERM_W + 2;
  localparam int ILO_W     = INTEG_W / 2;
  localparam int DLO_W     = TERM_W / 2;
  localparam int CFG_IDX_W = 3;
  localparam int MEM_W     = 2 * DATA_W + INTEG_W;

  localparam logic signed [SHR_W-1:0]  TERM_LIM  = SHR_W'(1) << (TERM_W - 2);
  localparam logic signed [SHR_W-1:0]  TERM_NLIM = -TERM_LIM;
  localparam logic signed [ISUM_W-1:0] INTEG_MAX = (ISUM_W'(1) << (INTEG_W - 1)) - ISUM_W'(1);
  localparam logic signed [ISUM_W-1:0] INTEG_MIN = -(ISUM_W'(1) << (INTEG_W - 1));
  localparam logic signed [SUM_W-1:0]  OUT_MAX   = (SUM_W'(1) << (DATA_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0]  OUT_MIN   = -(SUM_W'(1) << (DATA_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_TIMESTEP     = 3'd3,
    REG_INV_TIMESTEP = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]         joint_index;
    logic signed [DATA_W-1:0] measured_position;
    logic signed [DATA_W-1:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_joint;
    logic signed [DATA_W-1:0] drive_value;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic [DATA_W-1:0]        timestep;
    logic [DATA_W-1:0]        inv_timestep;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  prev_meas;
    logic signed [DATA_W-1:0]  prev_targ;
    logic signed [INTEG_W-1:0] integ;
  } mem_word_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [IDX_W-1:0] joint;
  } meta_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] joint;
    mem_word_t        data;
  } wb_t;

  typedef struct packed {
    meta_t                     meta;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [TERM_W-1:0]  tp;
  } fb_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // (p >> 16) truncated toward zero, clamped to +-2^60
  function automatic logic signed [TERM_W-1:0] q16_term(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0]        b;
    logic signed [SHR_W-1:0]  s;
    logic signed [SHR_W-1:0]  r;
    b = p + {{(PROD_W-16){1'b0}}, {16{p[PROD_W-1]}}};
    s = $signed(b[PROD_W-1:16]);
    if (s > TERM_LIM) begin
      r = TERM_LIM;
    end else if (s < TERM_NLIM) begin
      r = TERM_NLIM;
    end else begin
      r = s;
    end
    return r[TERM_W-1:0];
  endfunction

endpackage

// ===== hdl/mjpid_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
module mjpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mjpid_front.sv =====
// Front pipeline: joint state RAM, forwarding, integral update and error terms.
module mjpid_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                accept_i,
  input  mjpid_pkg::in_item_t in_item_i,
  input  mjpid_pkg::cfg_t     cfg_i,
  output mjpid_pkg::fb_t      fb_o
);
  import mjpid_pkg::*;

  meta_t                     s1_meta_q, s2_meta_q, s3_meta_q;
  in_item_t                  s1_item_q, s2_item_q, s3_item_q;
  logic signed [DATA_W:0]    err1, s2_err_q;
  logic signed [2*DATA_W+1:0] p1, s2_p1_q;
  logic signed [2*DATA_W:0]  pp, s3_pp_q;
  logic signed [TERM_W-1:0]  t1, s3_t1_q;
  logic [MEM_W-1:0]          rd_data;
  mem_word_t                 s2_rd_q, s3_rd_q;
  wb_t                       wb1_q, wb2_q, wb3_q;
  logic [JOINTS-1:0]         seen_q;
  logic                      bad0;
  logic [JW-1:0]             s3_addr;
  logic                      we;
  mem_word_t                 old_w, new_w;
  logic signed [ISUM_W-1:0]  integ_sum;
  logic signed [INTEG_W-1:0] integ_new;
  logic signed [DIFF_W-1:0]  diff;

  mjpid_ram #(
    .WIDTH(MEM_W),
    .DEPTH(JOINTS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s3_addr),
    .wdata_i(new_w),
    .re_i   (accept_i),
    .raddr_i(JW'(in_item_i.joint_index)),
    .rdata_o(rd_data)
  );

  assign bad0    = int'(in_item_i.joint_index) >= JOINTS;
  assign err1    = (DATA_W+1)'(s1_item_q.target_position)
                 - (DATA_W+1)'(s1_item_q.measured_position);
  assign p1      = err1 * $signed({1'b0, cfg_i.timestep});
  assign t1      = q16_term(PROD_W'(s2_p1_q));
  assign pp      = cfg_i.prop_gain * s2_err_q;
  assign s3_addr = JW'(s3_meta_q.joint);
  assign we      = adv_i & s3_meta_q.valid & ~s3_meta_q.bad;

  // newest write wins; unseen joint starts from its own target
  always_comb begin
    old_w = s3_rd_q;
    if (wb3_q.valid && wb3_q.joint == s3_meta_q.joint) begin
      old_w = wb3_q.data;
    end
    if (wb2_q.valid && wb2_q.joint == s3_meta_q.joint) begin
      old_w = wb2_q.data;
    end
    if (wb1_q.valid && wb1_q.joint == s3_meta_q.joint) begin
      old_w = wb1_q.data;
    end
    if (!seen_q[s3_addr]) begin
      old_w.prev_meas = s3_item_q.target_position;
      old_w.prev_targ = s3_item_q.target_position;
      old_w.integ     = '0;
    end
  end

  always_comb begin
    integ_sum = ISUM_W'(old_w.integ) + ISUM_W'(s3_t1_q);
    if (integ_sum > INTEG_MAX) begin
      integ_new = INTEG_W'(INTEG_MAX);
    end else if (integ_sum < INTEG_MIN) begin
      integ_new = INTEG_W'(INTEG_MIN);
    end else begin
      integ_new = INTEG_W'(integ_sum);
    end
  end

  assign diff = (DIFF_W'(s3_item_q.target_position) - DIFF_W'(old_w.prev_targ))
              - (DIFF_W'(s3_item_q.measured_position) - DIFF_W'(old_w.prev_meas));

  assign new_w = '{prev_meas: s3_item_q.measured_position,
                   prev_targ: s3_item_q.target_position,
                   integ:     integ_new};

  assign fb_o = '{meta:  s3_meta_q,
                  integ: integ_new,
                  diff:  diff,
                  tp:    q16_term(PROD_W'(s3_pp_q))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_meta_q <= '0;
      s2_meta_q <= '0;
      s3_meta_q <= '0;
      wb1_q     <= '0;
      wb2_q     <= '0;
      wb3_q     <= '0;
      seen_q    <= '0;
    end else if (adv_i) begin
      s1_meta_q <= '{valid: accept_i, bad: bad0, joint: in_item_i.joint_index};
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
      wb1_q     <= '{valid: s3_meta_q.valid & ~s3_meta_q.bad,
                     joint: s3_meta_q.joint,
                     data:  new_w};
      wb2_q     <= wb1_q;
      wb3_q     <= wb2_q;
      if (we) begin
        seen_q[s3_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_item_q <= in_item_i;
      s2_item_q <= s1_item_q;
      s2_err_q  <= err1;
      s2_p1_q   <= p1;
      s2_rd_q   <= mem_word_t'(rd_data);
      s3_item_q <= s2_item_q;
      s3_t1_q   <= t1;
      s3_pp_q   <= pp;
      s3_rd_q   <= s2_rd_q;
    end
  end

endmodule

// ===== hdl/mjpid_back.sv =====
// Back pipeline: split gain products, rate term and saturated output sum.
module mjpid_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  mjpid_pkg::fb_t  fb_i,
  input  mjpid_pkg::cfg_t cfg_i,
  output mjpid_pkg::res_t res_o
);
  import mjpid_pkg::*;

  meta_t s4_meta_q, s5_meta_q, s6_meta_q, s7_meta_q, s8_meta_q, s9_meta_q;

  logic signed [INTEG_W-1:0]              s4_integ_q;
  logic signed [DIFF_W-1:0]               s4_diff_q;
  logic signed [TERM_W-1:0]               s4_tp_q, s5_tp_q, s6_tp_q, s7_tp_q;
  logic signed [DATA_W+ILO_W:0]           ilo, s5_ilo_q;
  logic signed [DATA_W+INTEG_W-ILO_W-1:0] ihi, s5_ihi_q;
  logic signed [DIFF_W+DATA_W:0]          rp, s5_rp_q;
  logic signed [PROD_W-1:0]               pi, s6_pi_q;
  logic signed [TERM_W-1:0]               t_rate, s6_rate_q;
  logic signed [TERM_W-1:0]               t_i, s7_ti_q;
  logic signed [DATA_W+DLO_W:0]           dlo, s7_dlo_q;
  logic signed [DATA_W+TERM_W-DLO_W-1:0]  dhi, s7_dhi_q;
  logic signed [PROD_W-1:0]               pd, s8_pd_q;
  logic signed [SUM_W-1:0]                ps, s8_ps_q, s9_ps_q;
  logic signed [TERM_W-1:0]               t_d, s9_td_q;
  logic signed [SUM_W-1:0]                sum;
  logic signed [DATA_W-1:0]               drive;

  assign ilo    = cfg_i.integ_gain * $signed({1'b0, s4_integ_q[ILO_W-1:0]});
  assign ihi    = cfg_i.integ_gain * $signed(s4_integ_q[INTEG_W-1:ILO_W]);
  assign rp     = s4_diff_q * $signed({1'b0, cfg_i.inv_timestep});

  assign pi     = (PROD_W'(s5_ihi_q) <<< ILO_W) + PROD_W'(s5_ilo_q);
  assign t_rate = q16_term(PROD_W'(s5_rp_q));

  assign t_i    = q16_term(s6_pi_q);
  assign dlo    = cfg_i.deriv_gain * $signed({1'b0, s6_rate_q[DLO_W-1:0]});
  assign dhi    = cfg_i.deriv_gain * $signed(s6_rate_q[TERM_W-1:DLO_W]);

  assign pd     = (PROD_W'(s7_dhi_q) <<< DLO_W) + PROD_W'(s7_dlo_q);
  assign ps     = SUM_W'(s7_tp_q) + SUM_W'(s7_ti_q);

  assign t_d    = q16_term(s8_pd_q);

  assign sum    = s9_ps_q + SUM_W'(s9_td_q);

  always_comb begin
    if (s9_meta_q.bad) begin
      drive = '0;
    end else if (sum > OUT_MAX) begin
      drive = DATA_W'(OUT_MAX);
    end else if (sum < OUT_MIN) begin
      drive = DATA_W'(OUT_MIN);
    end else begin
      drive = DATA_W'(sum);
    end
  end

  assign res_o = '{valid: s9_meta_q.valid,
                   item:  '{out_joint: s9_meta_q.joint, drive_value: drive}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_meta_q <= '0;
      s5_meta_q <= '0;
      s6_meta_q <= '0;
      s7_meta_q <= '0;
      s8_meta_q <= '0;
      s9_meta_q <= '0;
    end else if (adv_i) begin
      s4_meta_q <= fb_i.meta;
      s5_meta_q <= s4_meta_q;
      s6_meta_q <= s5_meta_q;
      s7_meta_q <= s6_meta_q;
      s8_meta_q <= s7_meta_q;
      s9_meta_q <= s8_meta_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_integ_q <= fb_i.integ;
      s4_diff_q  <= fb_i.diff;
      s4_tp_q    <= fb_i.tp;
      s5_ilo_q   <= ilo;
      s5_ihi_q   <= ihi;
      s5_rp_q    <= rp;
      s5_tp_q    <= s4_tp_q;
      s6_pi_q    <= pi;
      s6_rate_q  <= t_rate;
      s6_tp_q    <= s5_tp_q;
      s7_ti_q    <= t_i;
      s7_dlo_q   <= dlo;
      s7_dhi_q   <= dhi;
      s7_tp_q    <= s6_tp_q;
      s8_pd_q    <= pd;
      s8_ps_q    <= ps;
      s9_td_q    <= t_d;
      s9_ps_q    <= s8_ps_q;
    end
  end

endmodule

// ===== hdl/multi_joint_pid.sv =====
// Top level of the multi-joint PID controller: config registers, pipeline and output skid.
//
// Takes one joint sample per clock while the skid register is empty and returns one
// saturated drive value per sample, in order, through the front stages, the back stages
// and the output register. Per-joint state (previous measurement, previous target, error
// integral) lives in one dual-port RAM that is read when a request is accepted and
// written back three stages later; three write-back registers forward fresh state so that
// samples for the same joint may follow each other in consecutive cycles. Seen flags are
// flip-flops cleared by reset, so no clearing pass is needed. Gains and periods may only
// be changed while the block is empty. A two-entry output buffer keeps requests flowing
// while the output stalls, until a result is held in its skid register.
module multi_joint_pid (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mjpid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mjpid_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mjpid_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mjpid_pkg::out_item_t                out_item_o
);
  import mjpid_pkg::*;

  cfg_t      cfg_q;
  fb_t       fb;
  res_t      res;
  logic      adv;
  logic      accept;
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  logic      out_free;

  assign cfg_ready_o = 1'b1;
  assign adv         = ~skid_valid_q;
  assign in_ready_o  = adv;
  assign accept      = in_valid_i & adv;
  assign out_free    = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data_i;
        REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data_i;
        REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data_i;
        REG_TIMESTEP:     cfg_q.timestep     <= cfg_data_i;
        REG_INV_TIMESTEP: cfg_q.inv_timestep <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mjpid_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .accept_i (accept),
    .in_item_i(in_item_i),
    .cfg_i    (cfg_q),
    .fb_o     (fb)
  );

  mjpid_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .fb_i  (fb),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res.valid;
      end
    end else if (res.valid && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res.item;
    end else if (!skid_valid_q) begin
      skid_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
